[src/fba_pkg.sv]
// Shared types, codes and constants of the frame bitmap allocator.
package fba_pkg;

  localparam int FRAME_W   = 12;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 13;
  localparam int BASE_W    = COUNT_W + 1;

  localparam int MAX_FRAMES_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;
  localparam int RESULT_REACH   = 4096;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SKIP   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_APPLY,
    ST_SCAN,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic [STATUS_W-1:0] status;
    logic                used;
    logic                present;
    logic                rw;
    logic                user;
  } result_t;

endpackage

[src/fba_req_if.sv]
// Request channel of the frame bitmap allocator.
interface fba_req_if;
  logic                         valid;
  logic                         ready;
  logic [fba_pkg::FUNC_W-1:0]   func;
  logic [fba_pkg::FRAME_W-1:0]  frame;
  logic                         supervisor;
  logic                         writable;

  modport source (output valid, func, frame, supervisor, writable, input ready);
  modport sink   (input valid, func, frame, supervisor, writable, output ready);
endinterface

[src/fba_rsp_if.sv]
// Response channel of the frame bitmap allocator.
interface fba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::FRAME_W-1:0]   result_frame;
  logic [fba_pkg::STATUS_W-1:0]  status;
  logic                          frame_used;
  logic                          present_bit;
  logic                          rw_bit;
  logic                          user_bit;

  modport source (output valid, result_frame, status, frame_used, present_bit, rw_bit,
                  user_bit, input ready);
  modport sink   (input valid, result_frame, status, frame_used, present_bit, rw_bit,
                  user_bit, output ready);
endinterface

[src/fba_map.sv]
// Used/free bitmap memory: one write port, one registered read port.
module fba_map #(
  parameter int WORD_BITS = fba_pkg::WORD_BITS_DEF,
  parameter int DEPTH     = 128,
  parameter int AW        = 7
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/fba_pick.sv]
// Lowest free bit of one bitmap word, limited to the frames still in range.
module fba_pick #(
  parameter int WORD_BITS = fba_pkg::WORD_BITS_DEF,
  parameter int BW        = 5
) (
  input  logic [WORD_BITS-1:0]       word,
  input  logic [fba_pkg::COUNT_W-1:0] remaining,
  output logic                        found,
  output logic [BW-1:0]               idx,
  output logic [WORD_BITS-1:0]        set_word
);

  localparam int CW = fba_pkg::COUNT_W;

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b] && (CW'(b) < remaining)) begin
        found = 1'b1;
        idx   = BW'(b);
      end
    end
  end

  assign set_word = word | (WORD_BITS'(1) << idx);

endmodule

[src/frame_bitmap_allocator.sv]
// Top level of the first-fit frame bitmap allocator.
// One request at a time. After reset the bitmap is cleared one word per cycle,
// ceil(min(MAX_FRAMES, 4096) / WORD_BITS) words (128 by default), with req.ready
// low. Allocate reads one bitmap word per cycle through the single read port and
// scans words up to the first free frame (at most ceil(limit / WORD_BITS) words,
// 128 by default). Free, mark and test of a frame inside the bitmap go through a
// reciprocal multiply for the word index, the bit offset and one word read; free
// and mark then write the word back. An allocate with a nonzero frame or no frame
// in range, a free of frame 0 or a frame outside the bitmap skips the bitmap. The
// finished word waits in an output register.
module frame_bitmap_allocator #(
  parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
  parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  fba_req_if.sink                       req,
  fba_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [fba_pkg::COUNT_W-1:0]   cfg_wdata
);

  localparam int FW           = fba_pkg::FRAME_W;
  localparam int CW           = fba_pkg::COUNT_W;
  localparam int BSW          = fba_pkg::BASE_W;
  localparam int REACH_FRAMES = (MAX_FRAMES < fba_pkg::RESULT_REACH) ?
                                MAX_FRAMES : fba_pkg::RESULT_REACH;
  localparam int MAP_WORDS    = (REACH_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW           = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW           = $clog2(WORD_BITS);
  localparam int DIV_S        = FW + BW;
  localparam int DIV_M        = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
  localparam int MW           = FW + 2;
  localparam int PW           = FW + MW;

  localparam logic [CW-1:0] REACH_C = CW'(REACH_FRAMES);

  fba_pkg::state_t  state, state_next;
  fba_pkg::result_t pend, pend_next;
  fba_pkg::result_t out_res;
  logic             rsp_valid;
  logic             load_out;

  logic [CW-1:0]    frame_count;
  logic [CW-1:0]    lim;

  logic [fba_pkg::FUNC_W-1:0] op;
  logic [FW-1:0]    frm;
  logic             kern;
  logic             wr;

  logic [AW-1:0]    clr_addr, clr_addr_next;
  logic [FW-1:0]    q;
  logic [PW-1:0]    prod;
  logic [FW-1:0]    qw;
  logic [BW-1:0]    bit_off;
  logic [WORD_BITS-1:0] mask;

  logic [AW-1:0]    issue_addr, issue_addr_next;
  logic [BSW-1:0]   issue_base, issue_base_next;
  logic             ev_vld, ev_vld_next;
  logic [BSW-1:0]   ev_base, ev_base_next;
  logic [AW-1:0]    ev_addr, ev_addr_next;
  logic             scan_more;

  logic             map_we;
  logic [AW-1:0]    map_waddr;
  logic [WORD_BITS-1:0] map_wdata;
  logic             map_re;
  logic [AW-1:0]    map_raddr;
  logic [WORD_BITS-1:0] map_rdata;

  logic             pick_found;
  logic [BW-1:0]    pick_idx;
  logic [WORD_BITS-1:0] pick_word;
  logic [CW-1:0]    remaining;

  fba_map #(
    .WORD_BITS (WORD_BITS),
    .DEPTH     (MAP_WORDS),
    .AW        (AW)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  assign remaining = lim - ev_base[CW-1:0];

  fba_pick #(
    .WORD_BITS (WORD_BITS),
    .BW        (BW)
  ) u_pick (
    .word      (map_rdata),
    .remaining (remaining),
    .found     (pick_found),
    .idx       (pick_idx),
    .set_word  (pick_word)
  );

  assign lim       = (frame_count > REACH_C) ? REACH_C : frame_count;
  assign prod      = PW'(frm) * PW'(DIV_M);
  assign qw        = q * FW'(WORD_BITS);
  assign mask      = WORD_BITS'(1) << bit_off;
  assign scan_more = issue_base < {1'b0, lim};

  assign req.ready        = (state == fba_pkg::ST_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.result_frame = out_res.frame;
  assign rsp.status       = out_res.status;
  assign rsp.frame_used   = out_res.used;
  assign rsp.present_bit  = out_res.present;
  assign rsp.rw_bit       = out_res.rw;
  assign rsp.user_bit     = out_res.user;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fba_pkg::ST_CLEAR;
      frame_count <= fba_pkg::COUNT_RESET;
      rsp_valid   <= 1'b0;
      clr_addr    <= '0;
      ev_vld      <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      ev_vld   <= ev_vld_next;
      if (cfg_we) begin
        frame_count <= cfg_wdata;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend       <= pend_next;
    issue_addr <= issue_addr_next;
    issue_base <= issue_base_next;
    ev_base    <= ev_base_next;
    ev_addr    <= ev_addr_next;
    q          <= FW'(prod >> DIV_S);
    bit_off    <= BW'(frm - qw);
    if (load_out) begin
      out_res <= pend;
    end
    if (req.valid && (state == fba_pkg::ST_IDLE)) begin
      op   <= req.func;
      frm  <= req.frame;
      kern <= req.supervisor;
      wr   <= req.writable;
    end
  end

  always_comb begin
    state_next      = state;
    pend_next       = pend;
    clr_addr_next   = clr_addr;
    issue_addr_next = issue_addr;
    issue_base_next = issue_base;
    ev_vld_next     = 1'b0;
    ev_base_next    = issue_base;
    ev_addr_next    = issue_addr;
    map_we          = 1'b0;
    map_waddr       = ev_addr;
    map_wdata       = pick_word;
    map_re          = 1'b0;
    map_raddr       = issue_addr;
    load_out        = 1'b0;

    unique case (state)
      fba_pkg::ST_CLEAR: begin
        map_we        = 1'b1;
        map_waddr     = clr_addr;
        map_wdata     = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(MAP_WORDS - 1)) begin
          state_next = fba_pkg::ST_IDLE;
        end
      end
      fba_pkg::ST_IDLE: begin
        if (req.valid) begin
          pend_next        = '0;
          pend_next.frame  = req.frame;
          pend_next.status = fba_pkg::STAT_DONE;
          unique case (req.func) inside
            fba_pkg::FUNC_ALLOC: begin
              if (req.frame != '0) begin
                pend_next.status = fba_pkg::STAT_SKIP;
                state_next       = fba_pkg::ST_PUT;
              end else if (lim == '0) begin
                pend_next.status = fba_pkg::STAT_NOFREE;
                state_next       = fba_pkg::ST_PUT;
              end else begin
                issue_addr_next = '0;
                issue_base_next = '0;
                state_next      = fba_pkg::ST_SCAN;
              end
            end
            fba_pkg::FUNC_FREE: begin
              pend_next.frame = '0;
              if (req.frame == '0) begin
                pend_next.status = fba_pkg::STAT_SKIP;
                state_next       = fba_pkg::ST_PUT;
              end else if ({1'b0, req.frame} < REACH_C) begin
                state_next = fba_pkg::ST_DIV;
              end else begin
                state_next = fba_pkg::ST_PUT;
              end
            end
            fba_pkg::FUNC_MARK, fba_pkg::FUNC_TEST: begin
              if ({1'b0, req.frame} < REACH_C) begin
                state_next = fba_pkg::ST_DIV;
              end else begin
                state_next = fba_pkg::ST_PUT;
              end
            end
            default: begin
              state_next = fba_pkg::ST_PUT;
            end
          endcase
        end
      end
      fba_pkg::ST_DIV: begin
        state_next = fba_pkg::ST_REM;
      end
      fba_pkg::ST_REM: begin
        map_re     = 1'b1;
        map_raddr  = q[AW-1:0];
        state_next = fba_pkg::ST_APPLY;
      end
      fba_pkg::ST_APPLY: begin
        map_waddr = q[AW-1:0];
        map_wdata = map_rdata | mask;
        unique case (op)
          fba_pkg::FUNC_FREE: begin
            map_we    = 1'b1;
            map_wdata = map_rdata & ~mask;
          end
          fba_pkg::FUNC_MARK: begin
            map_we = 1'b1;
          end
          fba_pkg::FUNC_TEST: begin
            pend_next.used = |(map_rdata & mask);
          end
          default: begin
            map_we = 1'b0;
          end
        endcase
        state_next = fba_pkg::ST_PUT;
      end
      fba_pkg::ST_SCAN: begin
        if (scan_more) begin
          map_re          = 1'b1;
          issue_addr_next = issue_addr + AW'(1);
          issue_base_next = issue_base + BSW'(WORD_BITS);
          ev_vld_next     = 1'b1;
        end
        if (ev_vld) begin
          if (pick_found) begin
            map_we            = 1'b1;
            pend_next.frame   = FW'(ev_base + BSW'(pick_idx));
            pend_next.present = 1'b1;
            pend_next.rw      = wr;
            pend_next.user    = ~kern;
            ev_vld_next       = 1'b0;
            state_next        = fba_pkg::ST_PUT;
          end else if (!scan_more) begin
            pend_next.frame  = '0;
            pend_next.status = fba_pkg::STAT_NOFREE;
            state_next       = fba_pkg::ST_PUT;
          end
        end
      end
      fba_pkg::ST_PUT: begin
        if (!rsp_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = fba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/fba_chk.sv]
// Port checker of the frame bitmap allocator, bound to the top level.
module fba_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [fba_pkg::FRAME_W-1:0]    rsp_result_frame,
  input logic [fba_pkg::STATUS_W-1:0]   rsp_status,
  input logic                           rsp_frame_used,
  input logic                           rsp_present_bit,
  input logic                           rsp_rw_bit,
  input logic                           rsp_user_bit
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_frame) &&
                                $stable(rsp_status))
    else $error("response dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_alloc_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_present_bit |-> rsp_status == fba_pkg::STAT_DONE && !rsp_frame_used)
    else $error("present page with bad status");

  a_flags_clear: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_present_bit |-> !rsp_rw_bit && !rsp_user_bit)
    else $error("page flags without present");

  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == fba_pkg::STAT_NOFREE |-> rsp_result_frame == '0)
    else $error("no free frame with nonzero frame");

endmodule

bind frame_bitmap_allocator fba_chk u_fba_chk (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_result_frame (rsp.result_frame),
  .rsp_status       (rsp.status),
  .rsp_frame_used   (rsp.frame_used),
  .rsp_present_bit  (rsp.present_bit),
  .rsp_rw_bit       (rsp.rw_bit),
  .rsp_user_bit     (rsp.user_bit)
);

[bench/frame_bitmap_allocator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the frame bitmap allocator: directed and random requests.
module frame_bitmap_allocator_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [fba_pkg::COUNT_W-1:0] cfg_wdata = '0;

  fba_req_if req();
  fba_rsp_if rsp();

  frame_bitmap_allocator DUT (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  bit frame_map [fba_pkg::RESULT_REACH];
  logic [fba_pkg::COUNT_W-1:0] count_model = fba_pkg::COUNT_RESET;
  fba_pkg::result_t expected_words[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatches = 0;
  int checked_words = 0;
  int sent_words = 0;
  int nofree_seen = 0;

  initial begin
    req.valid = 1'b0;
    req.func = fba_pkg::FUNC_TEST;
    req.frame = '0;
    req.supervisor = 1'b0;
    req.writable = 1'b0;
    rsp.ready = 1'b0;
  end

  function automatic fba_pkg::result_t predict_word(logic [fba_pkg::FUNC_W-1:0] func,
                                                    logic [fba_pkg::FRAME_W-1:0] frame,
                                                    logic kern, logic wr);
    fba_pkg::result_t r;
    int lim;
    bit found;
    r = '0;
    case (func)
      fba_pkg::FUNC_ALLOC: begin
        if (frame != 0) begin
          r.frame = frame;
          r.status = fba_pkg::STAT_SKIP;
        end else begin
          lim = (count_model > fba_pkg::RESULT_REACH) ? fba_pkg::RESULT_REACH :
                int'(count_model);
          found = 1'b0;
          for (int f = 0; f < lim && !found; f++) begin
            if (!frame_map[f]) begin
              found = 1'b1;
              frame_map[f] = 1'b1;
              r.frame = fba_pkg::FRAME_W'(f);
              r.present = 1'b1;
              r.rw = wr;
              r.user = ~kern;
            end
          end
          if (!found) r.status = fba_pkg::STAT_NOFREE;
        end
      end
      fba_pkg::FUNC_FREE: begin
        if (frame == 0) r.status = fba_pkg::STAT_SKIP;
        else frame_map[frame] = 1'b0;
      end
      fba_pkg::FUNC_MARK: begin
        frame_map[frame] = 1'b1;
        r.frame = frame;
      end
      default: begin
        r.used = frame_map[frame];
        r.frame = frame;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      rsp.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    fba_pkg::result_t got;
    fba_pkg::result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.result_frame, rsp.status, rsp.frame_used, rsp.present_bit, rsp.rw_bit,
              rsp.user_bit};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: frame %0d status %0d", got.frame, got.status);
      end else begin
        want = expected_words.pop_front();
        checked_words++;
        if (want.status == fba_pkg::STAT_NOFREE) nofree_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp frame %0d status %0d used %0b p/rw/u %0b%0b%0b, ",
                      "got frame %0d status %0d used %0b p/rw/u %0b%0b%0b"},
                     want.frame, want.status, want.used, want.present, want.rw, want.user,
                     got.frame, got.status, got.used, got.present, got.rw, got.user);
        end
      end
    end
  end

  task automatic send_word(input logic [fba_pkg::FUNC_W-1:0] func,
                           input logic [fba_pkg::FRAME_W-1:0] frame,
                           input logic kern, input logic wr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= func;
    req.frame <= frame;
    req.supervisor <= kern;
    req.writable <= wr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_words.push_back(predict_word(func, frame, kern, wr));
    sent_words++;
  endtask

  task automatic finish_words();
    req.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [fba_pkg::COUNT_W-1:0] value);
    finish_words();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    count_model = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [fba_pkg::FRAME_W-1:0] near_frame();
    int hi;
    hi = (count_model > 4087) ? 4095 : int'(count_model) + 8;
    if ($urandom_range(0, 9) < 6) return fba_pkg::FRAME_W'($urandom_range(0, hi));
    return fba_pkg::FRAME_W'($urandom_range(0, 4095));
  endfunction

  task automatic send_random_word();
    int pick;
    logic [fba_pkg::FRAME_W-1:0] frame;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      frame = ($urandom_range(0, 4) == 0) ? fba_pkg::FRAME_W'($urandom_range(1, 4095)) : '0;
      send_word(fba_pkg::FUNC_ALLOC, frame, 1'($urandom), 1'($urandom));
    end else if (pick < 65) begin
      send_word(fba_pkg::FUNC_FREE, near_frame(), 1'($urandom), 1'($urandom));
    end else if (pick < 80) begin
      send_word(fba_pkg::FUNC_MARK, near_frame(), 1'($urandom), 1'($urandom));
    end else begin
      send_word(fba_pkg::FUNC_TEST, near_frame(), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_basic_ops();
    send_word(fba_pkg::FUNC_TEST, 12'd0, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_TEST, 12'hFFF, 1'b1, 1'b1);
    send_word(fba_pkg::FUNC_ALLOC, 12'd0, 1'b0, 1'b1);
    send_word(fba_pkg::FUNC_ALLOC, 12'd0, 1'b1, 1'b0);
    send_word(fba_pkg::FUNC_ALLOC, 12'hFFF, 1'b0, 1'b1);
    send_word(fba_pkg::FUNC_MARK, 12'hFFF, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_TEST, 12'hFFF, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_MARK, 12'd2, 1'b1, 1'b1);
    send_word(fba_pkg::FUNC_ALLOC, 12'd0, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_FREE, 12'd0, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_FREE, 12'd1, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_ALLOC, 12'd0, 1'b1, 1'b1);
    send_word(fba_pkg::FUNC_FREE, 12'hFFF, 1'b1, 1'b0);
    send_word(fba_pkg::FUNC_TEST, 12'hFFF, 1'b0, 1'b1);
    send_word(fba_pkg::FUNC_MARK, 12'hAAA, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_TEST, 12'hAAA, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_TEST, 12'h555, 1'b1, 1'b1);
  endtask

  task automatic test_frame_limits();
    write_frame_count(13'd0);
    send_word(fba_pkg::FUNC_ALLOC, 12'd0, 1'b0, 1'b1);
    write_frame_count(13'd4);
    send_word(fba_pkg::FUNC_ALLOC, 12'd0, 1'b0, 1'b1);
    send_word(fba_pkg::FUNC_ALLOC, 12'd0, 1'b1, 1'b1);
    send_word(fba_pkg::FUNC_FREE, 12'd2, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_ALLOC, 12'd0, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_MARK, 12'd100, 1'b0, 1'b0);
    send_word(fba_pkg::FUNC_TEST, 12'd100, 1'b0, 1'b0);
    write_frame_count(13'h1FFF);
    send_word(fba_pkg::FUNC_ALLOC, 12'd0, 1'b1, 1'b0);
  endtask

  task automatic test_random_phase(input int count, input logic [fba_pkg::COUNT_W-1:0] limit);
    write_frame_count(limit);
    repeat (count) send_random_word();
  endtask

  task automatic test_receiver_holdoff();
    int saved_pct;
    write_frame_count(13'd64);
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_request = 300;
    repeat (30) send_random_word();
    send_idle_pct = saved_pct;
  endtask

  task automatic test_sender_pause();
    write_frame_count(13'd40);
    repeat (20) send_random_word();
    finish_words();
    repeat (20) send_random_word();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_frame_limits();

    send_idle_pct = 7;
    recv_idle_pct = 78;
    test_random_phase(250, 13'd4096);
    test_random_phase(250, 13'd37);
    test_receiver_holdoff();

    send_idle_pct = 78;
    recv_idle_pct = 7;
    test_random_phase(250, 13'h1FFF);
    test_random_phase(250, 13'd1);
    test_sender_pause();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(250, 13'd64);
    test_random_phase(250, 13'($urandom_range(2, 200)));

    finish_words();
    repeat (150) @(posedge clk);

    $display("covered %0d requests, %0d words checked, %0d with no free frame",
             sent_words, checked_words, nofree_seen);
    $display("limits from 0 to 8191, long receiver hold-off and sender pause included");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[frame_bitmap_allocator.f]
src/fba_pkg.sv
src/fba_req_if.sv
src/fba_rsp_if.sv
src/fba_map.sv
src/fba_pick.sv
src/frame_bitmap_allocator.sv
src/fba_chk.sv
bench/frame_bitmap_allocator_tb.sv
